>>> src/igrc_pkg.sv
// ----------------------------------------------------------------------------
// igrc_pkg
// Shared types and fixed field widths for the interval register colorer.
// ----------------------------------------------------------------------------
package igrc_pkg;

  localparam int PT_W   = 17;  // live range point, signed
  localparam int NREG_W = 6;   // num_regs register
  localparam int VIDX_W = 9;   // var_index result field
  localparam int RNUM_W = 5;   // reg_number result field

  localparam logic [NREG_W-1:0] NUM_REGS_RST = 6'd32;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } igrc_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // take the input word, restart the scan
    logic scan;    // walk the stored table
    logic commit;  // store the entry and load the result register
  } igrc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic scan_done;
    logic out_free;
  } igrc_sts_t;

endpackage

>>> src/igrc_ctrl.sv
// ----------------------------------------------------------------------------
// igrc_ctrl
// Sequencer: accept a word, scan the table, then commit the result.
// ----------------------------------------------------------------------------
module igrc_ctrl
  import igrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  igrc_sts_t sts,
  output igrc_cmd_t cmd
);

  igrc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.full || sts.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Wait here only while an earlier result is still unclaimed.
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/igrc_dp.sv
// ----------------------------------------------------------------------------
// igrc_dp
// Range table, interference scan, register pick and result register.
// ----------------------------------------------------------------------------
module igrc_dp
  import igrc_pkg::*;
#(
  parameter int MAX_VARS = 512,
  parameter int MAX_REGS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  igrc_cmd_t                cmd,
  output igrc_sts_t                sts,
  input  logic                     cfg_we,
  input  logic        [NREG_W-1:0] cfg_wdata,
  input  logic signed [PT_W-1:0]   start_point,
  input  logic signed [PT_W-1:0]   end_point,
  input  logic                     first_of_function,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [VIDX_W-1:0] var_index,
  output logic        [RNUM_W-1:0] reg_number,
  output logic                     spilled,
  output logic                     overflow
);

  localparam int IDX_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int CW    = $clog2(MAX_VARS + 1);
  localparam int RW    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int MW    = 2 * PT_W + RW + 1;

  logic [MW-1:0] mem [MAX_VARS];
  logic [MW-1:0] rd_data;
  logic          rd_vld;

  logic [NREG_W-1:0]      num_regs;
  logic [CW-1:0]          count;
  logic [CW-1:0]          scan_k;
  logic signed [PT_W-1:0] cur_s;
  logic signed [PT_W-1:0] cur_e;
  logic [MAX_REGS-1:0]    blocked;
  logic [MAX_REGS-1:0]    hit;

  logic signed [PT_W-1:0] rd_s;
  logic signed [PT_W-1:0] rd_e;
  logic [RW-1:0]          rd_reg;
  logic                   rd_has;
  logic                   full;

  logic          found;
  logic [RW-1:0] pick;
  logic [31:0]   count_ext;
  logic [31:0]   pick_ext;

  assign full   = (count == CW'(MAX_VARS));
  assign rd_s   = $signed(rd_data[MW-1 -: PT_W]);
  assign rd_e   = $signed(rd_data[RW+PT_W -: PT_W]);
  assign rd_reg = rd_data[RW:1];
  assign rd_has = rd_data[0];

  assign sts.full      = full;
  assign sts.scan_done = (scan_k == count) && !rd_vld;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_regs <= NUM_REGS_RST;
    end else if (cfg_we) begin
      num_regs <= cfg_wdata;
    end
  end

  // Registers held by stored ranges that overlap the current one.
  always_comb begin
    hit = '0;
    for (int j = 0; j < MAX_REGS; j++) begin
      if (rd_vld && rd_has && (rd_s <= cur_e) && (cur_s <= rd_e) &&
          (rd_reg == RW'(j))) begin
        hit[j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_s   <= start_point;
      cur_e   <= end_point;
      blocked <= '0;
    end else begin
      blocked <= blocked | hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_k <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.load) begin
      scan_k <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.scan && (scan_k < count)) begin
      scan_k <= scan_k + CW'(1);
      rd_vld <= 1'b1;
    end else begin
      rd_vld <= 1'b0;
    end
  end

  // Single read port; only entries below count are ever fetched.
  always_ff @(posedge clk) begin
    if (cmd.scan && (scan_k < count)) begin
      rd_data <= mem[scan_k[IDX_W-1:0]];
    end
  end

  // Lowest free register below min(num_regs, MAX_REGS).
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int j = MAX_REGS - 1; j >= 0; j--) begin
      if (!blocked[j] && (32'(j) < 32'(num_regs))) begin
        found = 1'b1;
        pick  = RW'(j);
      end
    end
  end

  assign count_ext = 32'(count);
  assign pick_ext  = 32'(pick);

  always_ff @(posedge clk) begin
    if (cmd.commit && !full) begin
      mem[count[IDX_W-1:0]] <= {cur_s, cur_e, (found ? pick : RW'(0)), found};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load && first_of_function) begin
      count <= '0;
    end else if (cmd.commit && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (full) begin
        var_index  <= '0;
        reg_number <= '0;
        spilled    <= 1'b0;
        overflow   <= 1'b1;
      end else begin
        var_index  <= count_ext[VIDX_W-1:0];
        reg_number <= found ? pick_ext[RNUM_W-1:0] : '0;
        spilled    <= !found;
        overflow   <= 1'b0;
      end
    end
  end

endmodule

>>> src/interval_greedy_register_coloring.sv
// ----------------------------------------------------------------------------
// interval_greedy_register_coloring
// Greedy register assignment for live ranges that arrive in index order.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid in_ready start_point end_point        | in
//           | first_of_function                              |
//   out     | out_valid out_ready var_index reg_number       | out
//           | spilled overflow                               |
//   cfg     | cfg_we cfg_wdata (num_regs)                    | in
//
// An item is accepted, then scanned with one registered table read per
// stored range through the single port of the range memory, then
// committed. A full table ends the scan without waiting for its reads.
// Reset clears the entry count and sets num_regs to 32; the table needs
// no clearing pass. A new word is taken while a result waits on out;
// commit stalls only while that earlier result is still unclaimed.
// ----------------------------------------------------------------------------
module interval_greedy_register_coloring
  import igrc_pkg::*;
#(
  parameter int MAX_VARS = 512,
  parameter int MAX_REGS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic        [NREG_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [PT_W-1:0]   start_point,
  input  logic signed [PT_W-1:0]   end_point,
  input  logic                     first_of_function,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [VIDX_W-1:0] var_index,
  output logic        [RNUM_W-1:0] reg_number,
  output logic                     spilled,
  output logic                     overflow
);

  igrc_cmd_t cmd;
  igrc_sts_t sts;

  igrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  igrc_dp #(
    .MAX_VARS (MAX_VARS),
    .MAX_REGS (MAX_REGS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .start_point       (start_point),
    .end_point         (end_point),
    .first_of_function (first_of_function),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .var_index         (var_index),
    .reg_number        (reg_number),
    .spilled           (spilled),
    .overflow          (overflow)
  );

  // Only one word is in flight: no new accept right after one.
  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is still in work");

  // A commit never overwrites a result that was not taken.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // An overflow result carries no assignment.
  a_overflow_clean : assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (!spilled && reg_number == '0 && var_index == '0))
    else $error("overflow word carries assignment fields");

  // A spilled variable reports register zero.
  a_spill_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && spilled) |-> (reg_number == '0 && !overflow))
    else $error("spilled word carries a register");

endmodule

>>> bench/interval_greedy_register_coloring_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_greedy_register_coloring_test
// Self-checking bench for the interval register colorer. A table of
// directed live ranges is followed by random functions of live ranges. The
// random part includes one function long enough to fill the range table
// and overrun it. A local predictor colors every accepted word, and each
// result word is checked against it in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module interval_greedy_register_coloring_test
  import igrc_pkg::*;
();

  localparam int VAR_LIMIT   = 512;
  localparam int REG_LIMIT   = 32;
  localparam int ITEM_TARGET = 700;
  localparam int TAIL_CYCLES = 600;

  typedef struct packed {
    logic [VIDX_W-1:0] idx;
    logic [RNUM_W-1:0] rnum;
    logic              spill;
    logic              ovf;
  } color_t;

  typedef struct packed {
    logic                   set_cfg;
    logic [NREG_W-1:0]      cfg_val;
    logic signed [PT_W-1:0] lo;
    logic signed [PT_W-1:0] hi;
    logic                   opens;
    logic                   typed;
    color_t                 want;
  } plan_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic        [NREG_W-1:0] cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [PT_W-1:0]   start_point = '0;
  logic signed [PT_W-1:0]   end_point = '0;
  logic                     first_of_function = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic        [VIDX_W-1:0] var_index;
  logic        [RNUM_W-1:0] reg_number;
  logic                     spilled;
  logic                     overflow;

  // Local copy of the colorer state.
  logic signed [PT_W-1:0] live_lo[VAR_LIMIT];
  logic signed [PT_W-1:0] live_hi[VAR_LIMIT];
  logic [5:0]             held_reg[VAR_LIMIT];
  logic                   has_reg[VAR_LIMIT];
  int                     n_live = 0;
  logic [NREG_W-1:0]      reg_budget = NUM_REGS_RST;

  color_t colors_due[$];
  plan_t  plan[$];
  bit     steady = 1'b0;
  int     mismatches = 0;
  int     ranges_sent = 0;
  int     spill_hits = 0;
  int     overflow_hits = 0;
  int     top_reg = 0;

  interval_greedy_register_coloring #(
    .MAX_VARS(VAR_LIMIT),
    .MAX_REGS(REG_LIMIT)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .start_point      (start_point),
    .end_point        (end_point),
    .first_of_function(first_of_function),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .var_index        (var_index),
    .reg_number       (reg_number),
    .spilled          (spilled),
    .overflow         (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("run timed out with %0d result words outstanding", colors_due.size());
    $display("interval_greedy_register_coloring test failed");
    $finish;
  end

  // Greedy coloring of one live range against the stored table.
  function automatic color_t color_range(input logic signed [PT_W-1:0] lo,
                                         input logic signed [PT_W-1:0] hi,
                                         input logic opens);
    logic [63:0] busy;
    color_t      r;
    int          lim;
    int          pick;
    logic        found;
    busy  = '0;
    r     = '0;
    pick  = 0;
    found = 1'b0;
    lim   = (reg_budget < REG_LIMIT) ? int'(reg_budget) : REG_LIMIT;
    if (opens) n_live = 0;
    if (n_live >= VAR_LIMIT) begin
      r.ovf = 1'b1;
      return r;
    end
    for (int k = 0; k < n_live; k++) begin
      if (has_reg[k] && live_lo[k] <= hi && lo <= live_hi[k]) busy[held_reg[k]] = 1'b1;
    end
    // Walk down so the lowest free register is the one left in pick.
    for (int k = lim - 1; k >= 0; k--) begin
      if (!busy[k]) begin
        pick  = k;
        found = 1'b1;
      end
    end
    live_lo[n_live]  = lo;
    live_hi[n_live]  = hi;
    held_reg[n_live] = found ? pick[5:0] : 6'd0;
    has_reg[n_live]  = found;
    r.idx   = n_live[VIDX_W-1:0];
    r.rnum  = found ? pick[RNUM_W-1:0] : '0;
    r.spill = !found;
    n_live++;
    return r;
  endfunction

  function automatic plan_t plan_step(input int set_cfg, input int budget,
                                      input int lo, input int hi, input int opens,
                                      input int typed, input int idx, input int rnum,
                                      input int spill);
    plan_t p;
    p            = '0;
    p.set_cfg    = (set_cfg != 0);
    p.cfg_val    = budget[NREG_W-1:0];
    p.lo         = lo[PT_W-1:0];
    p.hi         = hi[PT_W-1:0];
    p.opens      = (opens != 0);
    p.typed      = (typed != 0);
    p.want.idx   = idx[VIDX_W-1:0];
    p.want.rnum  = rnum[RNUM_W-1:0];
    p.want.spill = (spill != 0);
    return p;
  endfunction

  task automatic send_range(input logic signed [PT_W-1:0] lo,
                            input logic signed [PT_W-1:0] hi,
                            input logic opens, input logic typed, input color_t want);
    color_t got;
    while (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    start_point       <= lo;
    end_point         <= hi;
    first_of_function <= opens;
    do @(posedge clk); while (!in_ready);
    got = color_range(lo, hi, opens);
    ranges_sent++;
    colors_due.push_back(typed ? want : got);
  endtask

  // Drop valid and wait until every result word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_budget(input logic [NREG_W-1:0] value);
    settle();
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    reg_budget = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One function: live ranges clustered around a random base, with a few
  // unused variables, scattered ranges and reversed ranges mixed in.
  task automatic run_function(input int count, input int span, input int reach);
    int base;
    int pick;
    int lo;
    int hi;
    int tmp;
    logic opens;
    base = $urandom_range(65535 - span - reach);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        lo = -1;
        hi = -1;
      end else if (pick < 10) begin
        lo = $urandom_range(65535);
        hi = $urandom_range(65535);
      end else begin
        lo = base + $urandom_range(span);
        hi = lo + $urandom_range(reach);
        if (pick < 14) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      end
      // Short functions are sometimes cut off by an early restart.
      opens = (i == 0) || (count < 100 && $urandom_range(99) < 3);
      send_range(lo[PT_W-1:0], hi[PT_W-1:0], opens, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin : watch
    color_t want;
    if (!rst && out_valid && out_ready) begin
      if (colors_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word: var %0d reg %0d spill %b ovf %b", $realtime,
                   var_index, reg_number, spilled, overflow);
      end else begin
        want = colors_due.pop_front();
        if (var_index !== want.idx || reg_number !== want.rnum ||
            spilled !== want.spill || overflow !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: expected var %0d reg %0d spill %b ovf %b,",
                      " got var %0d reg %0d spill %b ovf %b"},
                     $realtime, want.idx, want.rnum, want.spill, want.ovf,
                     var_index, reg_number, spilled, overflow);
        end
      end
      if (spilled === 1'b1) spill_hits++;
      if (overflow === 1'b1) overflow_hits++;
      if (spilled === 1'b0 && overflow === 1'b0 && int'(reg_number) > top_reg)
        top_reg = int'(reg_number);
    end
  end

  initial begin
    int phase;
    int budget;

    // Reset count of 32 registers first, then none, one, an oversized count
    // and two, where a spilled range must not block later ones.
    plan.push_back(plan_step(0, 0, -1, -1, 1, 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, -1, -1, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, 65535, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 65535, 65535, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 10, 5, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 65535, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, -1, 65535, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(1, 0, 100, 200, 1, 1, 0, 0, 1));
    plan.push_back(plan_step(0, 0, 100, 200, 0, 1, 1, 0, 1));
    plan.push_back(plan_step(0, 0, -1, -1, 0, 1, 2, 0, 1));
    plan.push_back(plan_step(1, 1, 5, 10, 1, 1, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 7, 8, 0, 1, 1, 0, 1));
    plan.push_back(plan_step(0, 0, 11, 20, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 8, 12, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(1, 63, 0, 100, 1, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, 100, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 50, 60, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(1, 2, 0, 10, 1, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, 10, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 0, 10, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 5, 15, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 11, 20, 0, 0, 0, 0, 0));
    plan.push_back(plan_step(0, 0, 11, 20, 0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].set_cfg) set_budget(plan[r].cfg_val);
      send_range(plan[r].lo, plan[r].hi, plan[r].opens, plan[r].typed, plan[r].want);
    end

    phase = 0;
    while (ranges_sent < ITEM_TARGET) begin
      case (phase)
        0: budget = 32;
        1: budget = 0;
        2: budget = 1;
        3: budget = 63;
        default: budget = $urandom_range(2, 32);
      endcase
      set_budget(budget[NREG_W-1:0]);
      steady = (phase == 2);
      // Forty ranges, most of them sharing one start point, can exhaust every register.
      if (phase == 3) run_function(40, 0, 50);
      if (phase == 4) begin
        run_function(VAR_LIMIT + 4, 3000, 300);
        run_function(6, 200, 100);
      end else begin
        repeat ($urandom_range(2, 5))
          run_function($urandom_range(1, 30), $urandom_range(0, 600), $urandom_range(0, 300));
      end
      phase++;
    end
    steady = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d live ranges in %0d register settings: %0d spilled,",
             ranges_sent, phase + 5, spill_hits);
    $display("%0d refused on a full table, highest register assigned %0d, %0d mismatches",
             overflow_hits, top_reg, mismatches);
    if (mismatches == 0 && colors_due.size() == 0) begin
      $display("interval_greedy_register_coloring test passed");
    end else begin
      $display("interval_greedy_register_coloring test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/igrc_pkg.sv
src/igrc_ctrl.sv
src/igrc_dp.sv
src/interval_greedy_register_coloring.sv
bench/interval_greedy_register_coloring_test.sv
